### src/tpls_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the thermal print line sequencer
// no dependencies

package tpls_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROWS_IN_BAND = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_BYTES_PER_ROW = 8'd1;

  localparam logic [7:0] ROWS_IN_BAND_RST = 8'd28;
  localparam logic [7:0] BYTES_PER_ROW_RST = 8'd48;
  localparam logic [7:0] ROW_PTR_MAX = 8'd255;
  localparam logic [1:0] MOTOR_STEPS = 2'd2;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_TEMP = 3'd1,
    CMD_STEP = 3'd2,
    CMD_ROW  = 3'd3,
    CMD_OFF  = 3'd4,
    CMD_PWR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_BUSY    = 2'd1,
    ST_NOPAPER = 2'd2,
    ST_HOT     = 2'd3
  } status_e;

  // sequence step codes
  localparam logic [3:0] SEQ_STEP0  = 4'd0;
  localparam logic [3:0] SEQ_WAIT0  = 4'd1;
  localparam logic [3:0] SEQ_STEP2  = 4'd2;
  localparam logic [3:0] SEQ_WAIT2  = 4'd3;
  localparam logic [3:0] SEQ_ROW_A  = 4'd4;
  localparam logic [3:0] SEQ_HEAT_A = 4'd5;
  localparam logic [3:0] SEQ_STEP4  = 4'd6;
  localparam logic [3:0] SEQ_WAIT4  = 4'd7;
  localparam logic [3:0] SEQ_STEP6  = 4'd8;
  localparam logic [3:0] SEQ_WAIT6  = 4'd9;
  localparam logic [3:0] SEQ_ROW_B  = 4'd10;
  localparam logic [3:0] SEQ_HEAT_B = 4'd11;
  localparam logic [3:0] SEQ_CHECK  = 4'd12;
  localparam logic [3:0] SEQ_DONE   = 4'd14;

  localparam logic [2:0] PHASE_0 = 3'd0;
  localparam logic [2:0] PHASE_2 = 3'd2;
  localparam logic [2:0] PHASE_4 = 3'd4;
  localparam logic [2:0] PHASE_6 = 3'd6;

  typedef struct packed {
    logic [1:0] mode;
    logic       too_hot;
    logic       paper_present;
    logic       temp_detect_done;
    logic       motor_step_done;
    logic       heat_done;
  } req_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  motor_phase;
    logic [1:0]  motor_count;
    logic [7:0]  row_index;
    logic [15:0] row_offset;
    logic [7:0]  row_bytes;
    logic [1:0]  status;
    logic        accepted;
  } rsp_t;

  typedef struct packed {
    logic [7:0] rows_in_band;
    logic [7:0] bytes_per_row;
  } cfg_t;

  typedef struct packed {
    logic [1:0] printer_state;
    logic       running;
    logic [3:0] seq_step;
    logic [7:0] row_pointer;
  } seq_state_t;

endpackage

### src/tpls_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: print requests, results and register writes
// depends on tpls_pkg for widths

interface tpls_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       too_hot;
  logic       paper_present;
  logic       temp_detect_done;
  logic       motor_step_done;
  logic       heat_done;

  modport source (output valid, mode, too_hot, paper_present, temp_detect_done,
                  motor_step_done, heat_done, input ready);
  modport sink (input valid, mode, too_hot, paper_present, temp_detect_done,
                motor_step_done, heat_done, output ready);
endinterface

interface tpls_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [2:0]  motor_phase;
  logic [1:0]  motor_count;
  logic [7:0]  row_index;
  logic [15:0] row_offset;
  logic [7:0]  row_bytes;
  logic [1:0]  status;
  logic        accepted;

  modport source (output valid, command, motor_phase, motor_count, row_index,
                  row_offset, row_bytes, status, accepted, input ready);
  modport sink (input valid, command, motor_phase, motor_count, row_index,
                row_offset, row_bytes, status, accepted, output ready);
  modport mon (input valid, ready, command, motor_phase, motor_count, row_index,
               row_offset, row_bytes, status, accepted);
endinterface

interface tpls_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tpls_pkg::CfgIdxW-1:0]  index;
  logic [tpls_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/thermal_print_line_sequencer.sv
`timescale 1ns / 1ps
// top level of the thermal print line sequencer: state, registers, result register
// depends on tpls_pkg, tpls_if and tpls_step
//
// Usage:
//   req_i carries one event per request: a tick, start, stop or NOP, together with
//   the head sensor and done flags. rsp_o returns exactly one result per request:
//   the command for the head (temp detect, motor step, row write and heat, all
//   off, power on), its arguments and the refreshed status. cfg_i writes
//   rows_in_band (index 0) and bytes_per_row (index 1); other indexes are ignored.
//   Write registers only while no request is in flight.
//
//   A request accepted at one clock edge shows its result on rsp_o right
//   after that edge. Throughput: one request per cycle while rsp_o is not stalled;
//   all work is a single pass through the step logic into the result register.
//   Stall: while a result waits on rsp_o, req_i.ready follows rsp_o.ready, so a new
//   request is taken in the same cycle the waiting result leaves.
//   Reset: the sequencer goes idle and stopped, row 0, step 0; rows_in_band = 28,
//   bytes_per_row = 48; no result is pending. cfg_i is always ready.

module thermal_print_line_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpls_req_if.sink   req_i,
  tpls_rsp_if.source rsp_o,
  tpls_cfg_if.sink   cfg_i
);
  import tpls_pkg::*;

  seq_state_t state_q, state_d;
  cfg_t       cfg_q;
  rsp_t       rsp_q, rsp_d;
  logic       rsp_valid_q;
  req_t       req;
  logic       req_fire;

  assign req = '{mode:             req_i.mode,
                 too_hot:          req_i.too_hot,
                 paper_present:    req_i.paper_present,
                 temp_detect_done: req_i.temp_detect_done,
                 motor_step_done:  req_i.motor_step_done,
                 heat_done:        req_i.heat_done};

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  tpls_step u_step (
    .state_i (state_q),
    .req_i   (req),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      rsp_valid_q <= 1'b0;
      cfg_q       <= '{rows_in_band: ROWS_IN_BAND_RST, bytes_per_row: BYTES_PER_ROW_RST};
    end else begin
      if (req_fire) begin
        state_q <= state_d;
      end
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_ROWS_IN_BAND:  cfg_q.rows_in_band  <= cfg_i.data;
          CFG_BYTES_PER_ROW: cfg_q.bytes_per_row <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.command     = rsp_q.command;
  assign rsp_o.motor_phase = rsp_q.motor_phase;
  assign rsp_o.motor_count = rsp_q.motor_count;
  assign rsp_o.row_index   = rsp_q.row_index;
  assign rsp_o.row_offset  = rsp_q.row_offset;
  assign rsp_o.row_bytes   = rsp_q.row_bytes;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.accepted    = rsp_q.accepted;

endmodule

### src/tpls_step.sv
`timescale 1ns / 1ps
// next-state and result logic for one request of the print line sequencer
// depends on tpls_pkg

module tpls_step (
  input  tpls_pkg::seq_state_t state_i,
  input  tpls_pkg::req_t       req_i,
  input  tpls_pkg::cfg_t       cfg_i,
  output tpls_pkg::seq_state_t state_o,
  output tpls_pkg::rsp_t       rsp_o
);
  import tpls_pkg::*;

  seq_state_t nxt;
  rsp_t       rsp;
  logic [15:0] offset;
  logic        band_end;

  assign offset   = {8'd0, state_i.row_pointer} * {8'd0, cfg_i.bytes_per_row};
  assign band_end = state_i.row_pointer >= cfg_i.rows_in_band;

  always_comb begin
    nxt = state_i;
    rsp = '0;

    case (req_i.mode)
      MODE_START: begin
        if (req_i.too_hot) begin
          nxt.printer_state = ST_HOT;
        end else if (!req_i.paper_present) begin
          nxt.printer_state = ST_NOPAPER;
        end else begin
          nxt.printer_state = ST_BUSY;
          nxt.running       = 1'b1;
          nxt.seq_step      = SEQ_STEP0;
          nxt.row_pointer   = '0;
          rsp.command       = CMD_PWR;
          rsp.accepted      = 1'b1;
        end
      end
      MODE_STOP: begin
        nxt          = '0;
        rsp.command  = CMD_OFF;
        rsp.accepted = 1'b1;
      end
      MODE_TICK: begin
        if (state_i.running) begin
          if (!req_i.temp_detect_done) begin
            rsp.command = CMD_TEMP;
          end else begin
            case (state_i.seq_step)
              SEQ_STEP0, SEQ_STEP2, SEQ_STEP4, SEQ_STEP6: begin
                rsp.command     = CMD_STEP;
                rsp.motor_count = MOTOR_STEPS;
                case (state_i.seq_step)
                  SEQ_STEP0: rsp.motor_phase = PHASE_0;
                  SEQ_STEP2: rsp.motor_phase = PHASE_2;
                  SEQ_STEP4: rsp.motor_phase = PHASE_4;
                  default:   rsp.motor_phase = PHASE_6;
                endcase
                nxt.seq_step = state_i.seq_step + 4'd1;
              end
              SEQ_WAIT0, SEQ_WAIT2, SEQ_WAIT4, SEQ_WAIT6: begin
                if (req_i.motor_step_done) begin
                  nxt.seq_step = state_i.seq_step + 4'd1;
                end
              end
              SEQ_HEAT_A, SEQ_HEAT_B: begin
                if (req_i.heat_done) begin
                  nxt.seq_step = state_i.seq_step + 4'd1;
                end
              end
              SEQ_ROW_A, SEQ_ROW_B: begin
                // second write is skipped once the band is complete
                if (state_i.seq_step == SEQ_ROW_B && band_end) begin
                  nxt.seq_step = SEQ_CHECK;
                end else begin
                  rsp.command    = CMD_ROW;
                  rsp.row_index  = state_i.row_pointer;
                  rsp.row_offset = offset;
                  rsp.row_bytes  = cfg_i.bytes_per_row;
                  if (state_i.row_pointer != ROW_PTR_MAX) begin
                    nxt.row_pointer = state_i.row_pointer + 8'd1;
                  end
                  nxt.seq_step = state_i.seq_step + 4'd1;
                end
              end
              SEQ_CHECK: begin
                nxt.seq_step = band_end ? SEQ_DONE : SEQ_STEP0;
              end
              default: begin
                nxt         = '0;
                rsp.command = CMD_OFF;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase

    // status refresh from the sensor flags
    if (req_i.too_hot) begin
      nxt.printer_state = ST_HOT;
    end else if (nxt.printer_state == ST_HOT) begin
      nxt.printer_state = ST_IDLE;
    end
    if (!req_i.paper_present) begin
      nxt.printer_state = ST_NOPAPER;
    end else if (nxt.printer_state == ST_NOPAPER) begin
      nxt.printer_state = ST_IDLE;
    end
    rsp.status = nxt.printer_state;
  end

  assign state_o = nxt;
  assign rsp_o   = rsp;

endmodule

### src/tpls_checker.sv
`timescale 1ns / 1ps
// port-level assertions for the print line sequencer, bound to the top level
// depends on tpls_pkg and the result channel of the top level

module tpls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  command_i,
  input logic [1:0]  motor_count_i,
  input logic [7:0]  row_index_i,
  input logic [15:0] row_offset_i,
  input logic [7:0]  row_bytes_i,
  input logic [1:0]  status_i,
  input logic        accepted_i
);
  import tpls_pkg::*;

  logic [15:0] exp_offset;
  assign exp_offset = {8'd0, row_index_i} * {8'd0, row_bytes_i};

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(command_i) && $stable(status_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && accepted_i |-> command_i == CMD_PWR || command_i == CMD_OFF)
    else $error("accepted flag without power on or all off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (command_i == CMD_STEP) == (motor_count_i == MOTOR_STEPS))
    else $error("motor count does not match command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && command_i == CMD_ROW |-> row_offset_i == exp_offset)
    else $error("row offset is not row times bytes per row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && command_i == CMD_PWR |-> status_i == ST_BUSY)
    else $error("power on without busy status");

endmodule

bind thermal_print_line_sequencer tpls_checker u_tpls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .command_i     (rsp_o.command),
  .motor_count_i (rsp_o.motor_count),
  .row_index_i   (rsp_o.row_index),
  .row_offset_i  (rsp_o.row_offset),
  .row_bytes_i   (rsp_o.row_bytes),
  .status_i      (rsp_o.status),
  .accepted_i    (rsp_o.accepted)
);

### tb/tb.sv
`timescale 1ns / 1ps
// self-checking bench for thermal_print_line_sequencer: directed vectors, then random bands
// depends on tpls_pkg, tpls_if and the sequencer rtl

module tb;
  import tpls_pkg::*;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  tpls_req_if req_if ();
  tpls_rsp_if rsp_if ();
  tpls_cfg_if cfg_if ();

  thermal_print_line_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the sequencer
  logic [7:0] cfg_rows;
  logic [7:0] cfg_bytes;
  logic [1:0] head_status;
  logic       band_running;
  logic [3:0] seq_pos;
  logic [7:0] row_ptr;

  rsp_t      head_cmd_q[$];
  stim_row_t stim_rows[$];
  int        err_count = 0;
  bit        no_stall = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(3_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic note_error(string msg);
    $display("error @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic cmp_field(string name, int got, int want);
    if (got != want) begin
      note_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_head_cmd(rsp_t got, rsp_t want);
    cmp_field("command", got.command, want.command);
    cmp_field("motor_phase", got.motor_phase, want.motor_phase);
    cmp_field("motor_count", got.motor_count, want.motor_count);
    cmp_field("row_index", got.row_index, want.row_index);
    cmp_field("row_offset", got.row_offset, want.row_offset);
    cmp_field("row_bytes", got.row_bytes, want.row_bytes);
    cmp_field("status", got.status, want.status);
    cmp_field("accepted", got.accepted, want.accepted);
  endtask

  function automatic int draw_gap();
    return no_stall ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void clear_band();
    head_status  = ST_IDLE;
    band_running = 1'b0;
    seq_pos      = SEQ_STEP0;
    row_ptr      = '0;
  endfunction

  function automatic void motor_cmd(inout rsp_t o, input logic [2:0] ph,
                                    input logic [3:0] nxt);
    o.command     = CMD_STEP;
    o.motor_phase = ph;
    o.motor_count = MOTOR_STEPS;
    seq_pos       = nxt;
  endfunction

  function automatic void row_cmd(inout rsp_t o, input logic [3:0] nxt);
    o.command    = CMD_ROW;
    o.row_index  = row_ptr;
    o.row_offset = {8'd0, row_ptr} * {8'd0, cfg_bytes};
    o.row_bytes  = cfg_bytes;
    if (row_ptr < ROW_PTR_MAX) begin
      row_ptr = row_ptr + 8'd1;
    end
    seq_pos = nxt;
  endfunction

  function automatic rsp_t predict_head_cmd(req_t r);
    rsp_t o;
    o = '0;
    case (r.mode)
      MODE_START: begin
        if (r.too_hot) begin
          head_status = ST_HOT;
        end else if (!r.paper_present) begin
          head_status = ST_NOPAPER;
        end else begin
          head_status  = ST_BUSY;
          band_running = 1'b1;
          seq_pos      = SEQ_STEP0;
          row_ptr      = '0;
          o.command    = CMD_PWR;
          o.accepted   = 1'b1;
        end
      end
      MODE_STOP: begin
        clear_band();
        o.command  = CMD_OFF;
        o.accepted = 1'b1;
      end
      MODE_TICK: begin
        if (band_running) begin
          if (!r.temp_detect_done) begin
            o.command = CMD_TEMP;
          end else begin
            case (seq_pos)
              SEQ_STEP0:  motor_cmd(o, PHASE_0, SEQ_WAIT0);
              SEQ_WAIT0:  if (r.motor_step_done) seq_pos = SEQ_STEP2;
              SEQ_STEP2:  motor_cmd(o, PHASE_2, SEQ_WAIT2);
              SEQ_WAIT2:  if (r.motor_step_done) seq_pos = SEQ_ROW_A;
              SEQ_ROW_A:  row_cmd(o, SEQ_HEAT_A);
              SEQ_HEAT_A: if (r.heat_done) seq_pos = SEQ_STEP4;
              SEQ_STEP4:  motor_cmd(o, PHASE_4, SEQ_WAIT4);
              SEQ_WAIT4:  if (r.motor_step_done) seq_pos = SEQ_STEP6;
              SEQ_STEP6:  motor_cmd(o, PHASE_6, SEQ_WAIT6);
              SEQ_WAIT6:  if (r.motor_step_done) seq_pos = SEQ_ROW_B;
              SEQ_ROW_B: begin
                // band already complete: skip the second row write
                if (row_ptr >= cfg_rows) seq_pos = SEQ_CHECK;
                else row_cmd(o, SEQ_HEAT_B);
              end
              SEQ_HEAT_B: if (r.heat_done) seq_pos = SEQ_CHECK;
              SEQ_CHECK:  seq_pos = (row_ptr >= cfg_rows) ? SEQ_DONE : SEQ_STEP0;
              default: begin
                clear_band();
                o.command = CMD_OFF;
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    // sensor refresh on every request
    if (r.too_hot) head_status = ST_HOT;
    else if (head_status == ST_HOT) head_status = ST_IDLE;
    if (!r.paper_present) head_status = ST_NOPAPER;
    else if (head_status == ST_NOPAPER) head_status = ST_IDLE;
    o.status = head_status;
    return o;
  endfunction

  function automatic rsp_t plain_rsp(cmd_e c, status_e s, bit acc);
    rsp_t o;
    o          = '0;
    o.command  = c;
    o.status   = s;
    o.accepted = acc;
    return o;
  endfunction

  task automatic add_row(logic [1:0] m, bit hot, bit paper, bit td, bit md, bit hd,
                         bit typed, rsp_t want);
    stim_row_t s;
    s.req.mode             = m;
    s.req.too_hot          = hot;
    s.req.paper_present    = paper;
    s.req.temp_detect_done = td;
    s.req.motor_step_done  = md;
    s.req.heat_done        = hd;
    s.typed                = typed;
    s.want                 = want;
    stim_rows.push_back(s);
  endtask

  // mostly well-formed band traffic, a little raw noise
  function automatic req_t draw_req();
    req_t       r;
    logic [6:0] raw;
    int         pick;
    pick = $urandom_range(0, 99);
    r    = '0;
    if (!band_running && pick < 70) begin
      r.mode             = MODE_START;
      r.paper_present    = 1'b1;
      r.temp_detect_done = 1'($urandom_range(0, 1));
      r.motor_step_done  = 1'($urandom_range(0, 1));
      r.heat_done        = 1'($urandom_range(0, 1));
    end else if (pick < 94) begin
      r.mode             = MODE_TICK;
      r.too_hot          = ($urandom_range(0, 49) == 0);
      r.paper_present    = ($urandom_range(0, 49) != 0);
      r.temp_detect_done = ($urandom_range(0, 7) != 0);
      r.motor_step_done  = ($urandom_range(0, 2) != 0);
      r.heat_done        = ($urandom_range(0, 2) != 0);
    end else begin
      raw = 7'($urandom_range(0, 127));
      r   = raw;
    end
    return r;
  endfunction

  task automatic send_req(req_t r, bit typed, rsp_t want);
    int   gap;
    rsp_t pred;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.mode             <= r.mode;
    req_if.too_hot          <= r.too_hot;
    req_if.paper_present    <= r.paper_present;
    req_if.temp_detect_done <= r.temp_detect_done;
    req_if.motor_step_done  <= r.motor_step_done;
    req_if.heat_done        <= r.heat_done;
    do @(posedge clk_i); while (!req_if.ready);
    pred = predict_head_cmd(r);
    head_cmd_q.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_ROWS_IN_BAND) cfg_rows = data;
    else if (idx == CFG_BYTES_PER_ROW) cfg_bytes = data;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (head_cmd_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // result side
  initial begin
    int   gap;
    rsp_t got;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      @(negedge clk_i);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      got.command     = rsp_if.command;
      got.motor_phase = rsp_if.motor_phase;
      got.motor_count = rsp_if.motor_count;
      got.row_index   = rsp_if.row_index;
      got.row_offset  = rsp_if.row_offset;
      got.row_bytes   = rsp_if.row_bytes;
      got.status      = rsp_if.status;
      got.accepted    = rsp_if.accepted;
      if (head_cmd_q.size() == 0) begin
        note_error("result with no request pending");
      end else begin
        check_head_cmd(got, head_cmd_q.pop_front());
      end
    end
  end

  // request side and phases
  initial begin
    logic [7:0] rows_tab[4];
    logic [7:0] bytes_tab[4];
    logic [7:0] rows_val;
    logic [7:0] bytes_val;
    rows_tab  = '{8'd0, 8'd1, 8'd255, 8'd2};
    bytes_tab = '{8'd255, 8'd0, 8'd255, 8'd1};

    req_if.valid            = 1'b0;
    req_if.mode             = MODE_TICK;
    req_if.too_hot          = 1'b0;
    req_if.paper_present    = 1'b0;
    req_if.temp_detect_done = 1'b0;
    req_if.motor_step_done  = 1'b0;
    req_if.heat_done        = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = '0;
    cfg_if.data             = '0;
    cfg_rows                = ROWS_IN_BAND_RST;
    cfg_bytes               = BYTES_PER_ROW_RST;
    clear_band();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // mode, hot, paper, temp done, motor done, heat done
    add_row(MODE_TICK,  0, 1, 0, 0, 0, 1, plain_rsp(CMD_NONE, ST_IDLE, 0));
    add_row(MODE_NOP,   1, 1, 1, 1, 1, 1, plain_rsp(CMD_NONE, ST_HOT, 0));
    add_row(MODE_NOP,   0, 0, 0, 0, 0, 1, plain_rsp(CMD_NONE, ST_NOPAPER, 0));
    add_row(MODE_START, 1, 1, 0, 0, 0, 1, plain_rsp(CMD_NONE, ST_HOT, 0));
    add_row(MODE_START, 0, 0, 0, 0, 0, 1, plain_rsp(CMD_NONE, ST_NOPAPER, 0));
    add_row(MODE_STOP,  0, 1, 0, 0, 0, 1, plain_rsp(CMD_OFF, ST_IDLE, 1));
    add_row(MODE_TICK,  0, 1, 1, 1, 1, 1, plain_rsp(CMD_NONE, ST_IDLE, 0));
    add_row(MODE_START, 0, 1, 0, 0, 0, 1, plain_rsp(CMD_PWR, ST_BUSY, 1));
    add_row(MODE_TICK,  0, 1, 0, 1, 1, 1, plain_rsp(CMD_TEMP, ST_BUSY, 0));
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 1, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 1, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 1, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 1, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 1, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 1, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  0, 1, 1, 0, 0, 0, '0);
    add_row(MODE_TICK,  1, 1, 1, 0, 0, 0, '0);
    add_row(MODE_START, 0, 1, 1, 1, 1, 1, plain_rsp(CMD_PWR, ST_BUSY, 1));

    foreach (stim_rows[i]) begin
      send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph < 4) begin
        rows_val  = rows_tab[ph];
        bytes_val = bytes_tab[ph];
      end else begin
        rows_val  = 8'($urandom_range(0, 12));
        bytes_val = 8'($urandom_range(0, 255));
      end
      // unmapped index must be ignored
      write_reg((ph == 0) ? 8'hff : 8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
      write_reg(CFG_ROWS_IN_BAND, rows_val);
      write_reg(CFG_BYTES_PER_ROW, bytes_val);
      no_stall = (ph % 3 == 2);
      repeat (200) send_req(draw_req(), 1'b0, '0);
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/tpls_pkg.sv
src/tpls_if.sv
src/tpls_step.sv
src/thermal_print_line_sequencer.sv
src/tpls_checker.sv
tb/tb.sv
